>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the move-to-front coder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// Move-to-front coder package
// Shared types and constants for the cell chain and the controller.
// ----------------------------------------------------------------------------
package mtf_pkg;

   localparam int VALUE_W = 8;

   typedef logic [VALUE_W-1:0] value_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic      decode;         // 1: key is a position, 0: key is a symbol
      logic      load_identity;  // restore identity order this cycle
      value_type key;            // symbol or saturated position
   } bcast_type;

   // One slot of the token lane or the return lane.
   typedef struct packed {
      logic      valid;
      value_type data;
   } lane_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctrl_state_type;

   // Register index of decode_mode (paddr bit 2 selects the register).
   localparam logic REG_DECODE_MODE = 1'b0;

endpackage

>>> hw/rtl/mtf_cell.sv
// ----------------------------------------------------------------------------
// Move-to-front list cell
// Holds one list entry, forwards the update token and returns the answer.
// ----------------------------------------------------------------------------
module mtf_cell #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  mtf_pkg::bcast_type bc,
   input  mtf_pkg::lane_type tok_i,
   output mtf_pkg::lane_type tok_o,
   input  mtf_pkg::lane_type ret_i,
   output mtf_pkg::lane_type ret_o
);
   import mtf_pkg::*;

   localparam value_type MY_INDEX = value_type'(INDEX);
   localparam logic      IS_FRONT = (INDEX == 0);

   value_type value_ff, value_in;
   lane_type  tok_ff, tok_in;
   lane_type  ret_ff, ret_in;
   logic      hit;

   always_comb begin
      hit = tok_i.valid && (bc.decode ? (MY_INDEX == bc.key) : (value_ff == bc.key));

      value_in = value_ff;
      if (bc.load_identity) begin
         value_in = MY_INDEX;
      end else if (tok_i.valid) begin
         // take the entry from the cell in front, the token carries it
         value_in = tok_i.data;
      end else if (IS_FRONT && ret_ff.valid && bc.decode) begin
         // recovered symbol lands at the front
         value_in = ret_ff.data;
      end

      tok_in.valid = tok_i.valid && !hit;
      tok_in.data  = value_ff;

      if (hit) begin
         ret_in.valid = 1'b1;
         ret_in.data  = bc.decode ? value_ff : MY_INDEX;
      end else begin
         ret_in = ret_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= MY_INDEX;
         tok_ff   <= '0;
         ret_ff   <= '0;
      end else begin
         value_ff <= value_in;
         tok_ff   <= tok_in;
         ret_ff   <= ret_in;
      end
   end

   assign tok_o = tok_ff;
   assign ret_o = ret_ff;

endmodule

>>> hw/rtl/mtf_ctrl.sv
// ----------------------------------------------------------------------------
// Move-to-front controller
// Request and response handshake, register port and token launch.
// ----------------------------------------------------------------------------
module mtf_ctrl #(
   parameter int ALPHABET_SIZE = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic [0:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output mtf_pkg::bcast_type bc,
   output mtf_pkg::lane_type  tok0,
   input  mtf_pkg::lane_type  ret0
);
   import mtf_pkg::*;

   localparam logic [VALUE_W:0] LAST = (VALUE_W+1)'(ALPHABET_SIZE - 1);

   ctrl_state_type state_ff, state_in;
   logic           mode_ff, mode_in;
   value_type      key_ff, key_in;
   lane_type       tok_ff, tok_in;
   logic           rsp_valid_ff, rsp_valid_in;
   value_type      rsp_data_ff, rsp_data_in;
   logic           accept, out_of_range, miss, csr_write;

   always_comb begin
      out_of_range = {1'b0, req_tdata} > LAST;
      miss         = !mode_ff && out_of_range;
      req_tready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
      accept       = req_tvalid && req_tready;

      key_in = key_ff;
      if (accept) begin
         key_in = (mode_ff && out_of_range) ? LAST[VALUE_W-1:0] : req_tdata;
      end

      tok_in.valid = accept && !miss;
      tok_in.data  = req_tdata;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept && miss) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
      end else if (ret0.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ret0.data;
      end

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !miss) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (ret0.valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
      mode_in   = mode_ff;
      if (csr_write && (csr_paddr[2] == REG_DECODE_MODE)) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         tok_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         tok_ff       <= tok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign bc.decode        = mode_ff;
   assign bc.load_identity = accept && req_tuser[0];
   assign bc.key           = key_ff;
   assign tok0             = tok_ff;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr[2] == REG_DECODE_MODE) ? {31'b0, mode_ff} : 32'b0;

endmodule

>>> hw/rtl/move_to_front_coder.sv
// The token for a symbol at list position k goes from the controller out to cell k, and
// the answer walks back on the return lane to cell 0 and into the response register.
// A new request waits until the response appears and rsp_tready is high or it has gone.
// An absent symbol (encode mode) is answered with zero by the controller, with no token.
// Reset (synchronous, active high): list in identity order, encode mode, lanes empty.
// ----------------------------------------------------------------------------
// Move-to-front coder
// Recency list of byte values kept in a chain of cells; encodes or decodes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module move_to_front_coder #(
   parameter int ALPHABET_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] value_in
   input  logic [0:0]  req_tuser,   // [0] block_start
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] value_out
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mtf_pkg::*;

   // How one request moves through the chain:
   //  - The controller latches the key (symbol, or saturated position) and
   //    launches a token into cell 0. A block_start request reloads the
   //    identity order in every cell at the accepting edge.
   //  - Each cell the token reaches takes the entry of the cell in front
   //    (carried by the token) and hands its own entry on, so the list
   //    shifts back by one behind the token.
   //  - The cell that matches keeps the carried entry, drops the token and
   //    puts the answer on the return lane: its index when encoding, its
   //    old entry (the symbol) when decoding.
   //  - The return lane walks the answer back to cell 0. When decoding,
   //    cell 0 stores the recovered symbol as it passes, completing the
   //    move to front.

   bcast_type bc;
   lane_type  tok_lane [ALPHABET_SIZE+1];
   lane_type  ret_lane [ALPHABET_SIZE+1];
   logic [ALPHABET_SIZE:0]   tok_valid;
   logic [ALPHABET_SIZE-1:0] ret_valid;

   mtf_ctrl #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .bc         (bc),
      .tok0       (tok_lane[0]),
      .ret0       (ret_lane[0])
   );

   // Nothing returns from beyond the last cell.
   assign ret_lane[ALPHABET_SIZE] = '0;

   for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
      mtf_cell #(
         .INDEX(k)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .bc   (bc),
         .tok_i(tok_lane[k]),
         .tok_o(tok_lane[k+1]),
         .ret_i(ret_lane[k+1]),
         .ret_o(ret_lane[k])
      );
      assign ret_valid[k] = ret_lane[k].valid;
   end

   for (genvar k = 0; k <= ALPHABET_SIZE; k++) begin : g_tok_valid
      assign tok_valid[k] = tok_lane[k].valid;
   end

   // One request in flight: at most one token, at most one returning answer,
   // never both at once, and a token always finds its cell.
   `ASSERT_ALWAYS(a_one_token, clock, reset, $onehot0(tok_valid), "more than one token in chain")
   `ASSERT_ALWAYS(a_one_answer, clock, reset, $onehot0(ret_valid), "more than one answer returning")
   `ASSERT_IMPLY(a_token_xor_answer, clock, reset, |tok_valid, !(|ret_valid), "token and answer coexist")
   `ASSERT_ALWAYS(a_token_found, clock, reset, !tok_valid[ALPHABET_SIZE], "token ran off chain end")

endmodule
